// ===== src/mrr_pkg.sv =====
package mrr_pkg;

  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned MAX_RULES = 8;
  localparam int unsigned REG_W     = 27;
  localparam int unsigned IDX_W     = 3;

  localparam logic [REG_W-1:0] RULE_RESET = 27'h600_0000;

  localparam logic [2:0] EV_NOTE_ON  = 3'd0;
  localparam logic [2:0] EV_NOTE_OFF = 3'd1;
  localparam logic [2:0] EV_CC       = 3'd2;

  localparam logic [4:0] CH_MAX = 5'd16;

  localparam logic signed [6:0] TR_MAX  = 7'sd48;
  localparam logic signed [6:0] TR_MIN  = -7'sd48;
  localparam logic signed [7:0] VO_MIN  = -8'sd127;
  localparam logic signed [7:0] VO_LOW  = -8'sd128;
  localparam logic [6:0]        DATA_MAX = 7'd127;

  typedef struct packed {
    logic              pass_cc;
    logic              pass_notes;
    logic signed [7:0] vel_off;
    logic signed [6:0] transpose;
    logic [3:0]        out_ch;
    logic [4:0]        in_ch;
    logic              en;
  } rule_t;

  typedef struct packed {
    logic [2:0]           ev_type;
    logic [4:0]           channel;
    logic [6:0]           data1;
    logic [6:0]           data2;
    logic [15:0]          sample_offset;
    logic [MAX_RULES-1:0] mask;
    logic                 pass;
  } job_t;

  typedef struct packed {
    logic [2:0]  ev_type;
    logic [4:0]  channel;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [15:0] sample_offset;
    logic        last;
  } result_t;

endpackage

// ===== src/mrr_front.sv =====
module mrr_front #(
  parameter int unsigned RULE_COUNT = 8
) (
  input  logic [2:0]      event_type_i,
  input  logic [4:0]      channel_i,
  input  logic [6:0]      data1_i,
  input  logic [6:0]      data2_i,
  input  logic [15:0]     sample_offset_i,
  input  mrr_pkg::rule_t  rules_i [mrr_pkg::NUM_REGS],
  input  logic            accept_i,
  output logic            job_push_o,
  output mrr_pkg::job_t   job_o
);
  import mrr_pkg::*;

  logic                 is_note;
  logic                 is_cc;
  logic [MAX_RULES-1:0] used;
  logic [MAX_RULES-1:0] admit;
  logic [4:0]           ich [MAX_RULES];

  assign is_note = (event_type_i == EV_NOTE_ON) || (event_type_i == EV_NOTE_OFF);
  assign is_cc   = (event_type_i == EV_CC);

  always_comb begin
    used  = '0;
    admit = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      ich[i] = (rules_i[i].in_ch > CH_MAX) ? CH_MAX : rules_i[i].in_ch;
      if (i < RULE_COUNT) begin
        used[i] = rules_i[i].en && ((ich[i] == 5'd0) || (ich[i] == channel_i));
        if (is_note) begin
          admit[i] = used[i] && rules_i[i].pass_notes;
        end else if (is_cc) begin
          admit[i] = used[i] && rules_i[i].pass_cc;
        end else begin
          admit[i] = used[i];
        end
      end
    end
  end

  always_comb begin
    job_o.ev_type       = event_type_i;
    job_o.channel       = channel_i;
    job_o.data1         = data1_i;
    job_o.data2         = data2_i;
    job_o.sample_offset = sample_offset_i;
    job_o.mask          = admit;
    job_o.pass          = ~(|used);
  end

  // events that match rules but are admitted by none are dropped here
  assign job_push_o = accept_i && (job_o.pass || (|admit));

endmodule

// ===== src/mrr_queue.sv =====
module mrr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mrr_pkg::job_t data_o
);
  import mrr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/mrr_back.sv =====
module mrr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrr_pkg::rule_t   rules_i [mrr_pkg::NUM_REGS],
  input  logic             job_empty_i,
  input  mrr_pkg::job_t    job_i,
  output logic             job_pop_o,
  output logic             res_valid_o,
  output mrr_pkg::result_t res_o,
  input  logic             res_pop_i
);
  import mrr_pkg::*;

  logic                 busy_q, busy_d;
  job_t                 job_q, job_d;
  logic [MAX_RULES-1:0] rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  logic                 adv;
  logic                 emit;
  logic                 last;
  logic [IDX_W-1:0]     idx;
  logic [MAX_RULES-1:0] rem_next;
  rule_t                rule;
  logic                 is_note;
  logic signed [6:0]    tr;
  logic signed [7:0]    vo;
  logic signed [8:0]    key_sum;
  logic signed [9:0]    vel_sum;
  logic [6:0]           key;
  logic [6:0]           vel;

  assign adv      = !out_valid_q || res_pop_i;
  assign emit     = busy_q && adv;
  assign rem_next = rem_q & (rem_q - MAX_RULES'(1));
  assign last     = job_q.pass || (rem_next == '0);

  always_comb begin
    idx = '0;
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign rule    = rules_i[idx];
  assign is_note = (job_q.ev_type == EV_NOTE_ON) || (job_q.ev_type == EV_NOTE_OFF);

  always_comb begin
    priority if (rule.transpose > TR_MAX) begin
      tr = TR_MAX;
    end else if (rule.transpose < TR_MIN) begin
      tr = TR_MIN;
    end else begin
      tr = rule.transpose;
    end
    vo = (rule.vel_off == VO_LOW) ? VO_MIN : rule.vel_off;
    key_sum = $signed({2'b00, job_q.data1}) + $signed({{2{tr[6]}}, tr});
    vel_sum = $signed({3'b000, job_q.data2}) + $signed({{2{vo[7]}}, vo});
    priority if (key_sum[8]) begin
      key = '0;
    end else if (key_sum[7]) begin
      key = DATA_MAX;
    end else begin
      key = key_sum[6:0];
    end
    priority if (vel_sum[9]) begin
      vel = '0;
    end else if (vel_sum[8] || vel_sum[7]) begin
      vel = DATA_MAX;
    end else begin
      vel = vel_sum[6:0];
    end
  end

  assign job_pop_o = !job_empty_i && (!busy_q || (emit && last));

  always_comb begin
    busy_d      = busy_q;
    job_d       = job_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.ev_type       = job_q.ev_type;
      out_d.sample_offset = job_q.sample_offset;
      out_d.last          = last;
      if (job_q.pass) begin
        out_d.channel = job_q.channel;
        out_d.data1   = job_q.data1;
        out_d.data2   = job_q.data2;
      end else begin
        out_d.channel = {1'b0, rule.out_ch} + 5'd1;
        out_d.data1   = is_note ? key : job_q.data1;
        out_d.data2   = is_note ? vel : job_q.data2;
      end
      rem_d = rem_next;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (job_pop_o) begin
      busy_d = 1'b1;
      job_d  = job_i;
      rem_d  = job_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ===== src/midi_rule_router.sv =====
// midi_rule_router: routes MIDI events through up to eight packed rules.
// input channel: queue style, an event transaction is taken on a clock edge
//   with push_i high and full_o low; full_o rises only while the internal
//   job queue between classifier and emitter is full.
// result channel: queue style, the oldest result sits on the out_* ports
//   while empty_o is low and leaves on a clock edge with pop_i high.
// configuration: cfg_we_i writes cfg_data_i into rule cfg_index_i at once;
//   write only while no event is in flight.
// path: an event is written into the job queue, then loaded into the emitter's job
//   register, and its first result shows on empty_o from the result register.
// throughput: one result per cycle from the emitter while the result register is
//   empty or being popped; an event with n admitted copies yields n results (1 on
//   pass-through, up to RULE_COUNT); dropped events never reach the emitter. A new
//   event can be taken every cycle while the job queue has room.
// reset: rules return to their reset value (disabled), queues empty.
// stall: with pop_i low the result register holds; the emitter stops, the
//   job queue fills and then full_o holds off further events.
module midi_rule_router #(
  parameter int unsigned RULE_COUNT  = 8,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  event_type_i,
  input  logic [4:0]  channel_i,
  input  logic [6:0]  data1_i,
  input  logic [6:0]  data2_i,
  input  logic [15:0] sample_offset_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  out_type_o,
  output logic [4:0]  out_channel_o,
  output logic [6:0]  out_data1_o,
  output logic [6:0]  out_data2_o,
  output logic [15:0] out_sample_offset_o,
  output logic        last_of_run_o,
  input  logic        cfg_we_i,
  input  logic [mrr_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [mrr_pkg::REG_W-1:0] cfg_data_i
);
  import mrr_pkg::*;

  rule_t   rule_q [NUM_REGS];
  logic    accept;
  logic    job_push;
  job_t    job_in;
  logic    job_pop;
  logic    job_empty;
  job_t    job_head;
  logic    res_valid;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rule_q[i] <= rule_t'(RULE_RESET);
      end
    end else if (cfg_we_i) begin
      rule_q[cfg_index_i] <= rule_t'(cfg_data_i);
    end
  end

  assign accept = push_i && !full_o;

  mrr_front #(
    .RULE_COUNT(RULE_COUNT)
  ) u_front (
    .event_type_i   (event_type_i),
    .channel_i      (channel_i),
    .data1_i        (data1_i),
    .data2_i        (data2_i),
    .sample_offset_i(sample_offset_i),
    .rules_i        (rule_q),
    .accept_i       (accept),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  mrr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (full_o),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (job_head)
  );

  mrr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rules_i    (rule_q),
    .job_empty_i(job_empty),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_pop_i  (pop_i)
  );

  assign empty_o             = !res_valid;
  assign out_type_o          = res.ev_type;
  assign out_channel_o       = res.channel;
  assign out_data1_o         = res.data1;
  assign out_data2_o         = res.data2;
  assign out_sample_offset_o = res.sample_offset;
  assign last_of_run_o       = res.last;

endmodule

// ===== src/mrr_checker.sv =====
module mrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_o,
  input logic        empty_o,
  input logic        pop_i,
  input logic [2:0]  out_type_o,
  input logic [4:0]  out_channel_o,
  input logic [6:0]  out_data1_o,
  input logic [6:0]  out_data2_o,
  input logic [15:0] out_sample_offset_o,
  input logic        last_of_run_o
);

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o)
    else $error("result dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> $stable({out_type_o, out_channel_o, out_data1_o,
                                     out_data2_o, out_sample_offset_o, last_of_run_o}))
    else $error("result changed while stalled");

  a_full_needs_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("job queue filled without an event transaction");

  a_reset_idle : assert property (@(posedge clk_i)
    !rst_ni |=> empty_o && !full_o)
    else $error("block not idle after reset");

endmodule

bind midi_rule_router mrr_checker u_mrr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .push_i             (push_i),
  .full_o             (full_o),
  .empty_o            (empty_o),
  .pop_i              (pop_i),
  .out_type_o         (out_type_o),
  .out_channel_o      (out_channel_o),
  .out_data1_o        (out_data1_o),
  .out_data2_o        (out_data2_o),
  .out_sample_offset_o(out_sample_offset_o),
  .last_of_run_o      (last_of_run_o)
);
